[rtl/tcpnat_pkg.sv]
// tcpnat_pkg: shared constants, codes and checksum/address helpers
// for the TCP redirect NAT table. No dependencies.
`default_nettype none
package tcpnat_pkg;

    localparam int TABLE_SETS_DEF = 256;
    localparam int TABLE_WAYS_DEF = 4;
    localparam int CLIENT_W       = 48;

    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_DROP  = 2'd1;
    localparam logic [1:0] VERDICT_ROUTE = 2'd2;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [15:0] PORT_DNS  = 16'd53;

    localparam logic [1:0] REG_ROUTE_IF = 2'd0;
    localparam logic [1:0] REG_REDIR_IP = 2'd1;
    localparam logic [1:0] REG_REDIR_PT = 2'd2;

    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_ACK = 4;

    // Incremental checksum update (RFC 1624), wide covers a 32-bit field.
    function automatic logic [15:0] csum_fix(input logic [15:0] hc, input logic [31:0] old_v,
                                             input logic [31:0] new_v, input logic wide);
        logic [18:0] s;
        logic [16:0] s1;
        logic [16:0] s2;
        s = {3'd0, ~hc} + {3'd0, ~old_v[15:0]} + {3'd0, new_v[15:0]};
        if (wide)
        begin
            s = s + {3'd0, ~old_v[31:16]} + {3'd0, new_v[31:16]};
        end
        s1 = {1'b0, s[15:0]} + {14'd0, s[18:16]};
        s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
        return ~s2[15:0];
    endfunction

    function automatic logic is_lan(input logic [31:0] a);
        logic [7:0] o1;
        logic [7:0] o2;
        o1 = a[31:24];
        o2 = a[23:16];
        return (a == 32'hffff_ffff) || (o1 == 8'd127) || (o1 == 8'd10) ||
               ((o1 == 8'd172) && (o2 >= 8'd16) && (o2 <= 8'd31)) ||
               ((o1 == 8'd192) && (o2 == 8'd168));
    endfunction

    function automatic logic [31:0] client_hash(input logic [CLIENT_W-1:0] c);
        logic [CLIENT_W-1:0] h;
        h = c ^ (c >> 13) ^ (c >> 29);
        return h[31:0];
    endfunction

endpackage
`default_nettype wire

[rtl/tcpnat_setmod.sv]
// tcpnat_setmod: reduces a 32-bit hash modulo the set count.
// Mask for a power-of-two count, else reciprocal multiply, then a registered remainder with one correction.
`default_nettype none
module tcpnat_setmod #(
    parameter int TABLE_SETS = tcpnat_pkg::TABLE_SETS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [31:0]                   value,
    output logic                               done,
    output logic [$clog2(TABLE_SETS)-1:0]      result
);
    localparam int SET_W = $clog2(TABLE_SETS);
    localparam bit POW2  = ((1 << SET_W) == TABLE_SETS);

    generate
        if (POW2)
        begin : g_mask
            assign done   = start;
            assign result = value[SET_W-1:0];
        end
        else
        begin : g_recip
            // quotient estimate is low by at most one, so one correction step
            localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_SETS));

            logic [31:0]    quo_reg;
            logic [31:0]    val_reg;
            logic           stage_reg;
            logic           done_reg;
            logic [SET_W:0] rem_reg;
            logic [63:0]    prod;
            logic [31:0]    back;
            logic [31:0]    diff;
            logic [SET_W:0] fixed;

            always_comb
            begin
                prod  = 64'(value) * 64'(RECIP);
                back  = quo_reg * 32'(TABLE_SETS);
                diff  = val_reg - back;
                fixed = rem_reg;
                if (rem_reg >= (SET_W+1)'(TABLE_SETS))
                begin
                    fixed = rem_reg - (SET_W+1)'(TABLE_SETS);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg <= 1'b0;
                    done_reg  <= 1'b0;
                    quo_reg   <= '0;
                    val_reg   <= '0;
                    rem_reg   <= '0;
                end
                else
                begin
                    stage_reg <= start;
                    done_reg  <= stage_reg;
                    if (start)
                    begin
                        quo_reg <= prod[63:32];
                        val_reg <= value;
                    end
                    if (stage_reg)
                    begin
                        rem_reg <= diff[SET_W:0];
                    end
                end
            end

            assign done   = done_reg;
            assign result = fixed[SET_W-1:0];
        end
    endgenerate
endmodule
`default_nettype wire

[rtl/tcpnat_table.sv]
// tcpnat_table: one row per set holding all ways, synchronous RAM with
// one write port and one registered read port. Depends on tcpnat_pkg.
`default_nettype none
module tcpnat_table #(
    parameter int TABLE_SETS = tcpnat_pkg::TABLE_SETS_DEF,
    parameter int ROW_W      = 8
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(TABLE_SETS)-1:0] wr_addr,
    input  wire logic [ROW_W-1:0]              wr_data,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(TABLE_SETS)-1:0] rd_addr,
    output logic [ROW_W-1:0]                   rd_data
);
    logic [ROW_W-1:0] mem [TABLE_SETS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

[rtl/tcp_redirect_nat_table.sv]
// tcp_redirect_nat_table: TCP destination NAT with a set-associative
// connection table. A request is captured in ST_IDLE, classified in ST_PREP
// and its result registered in ST_EXEC; a table lookup when the set count is
// not a power of two also waits in ST_MODW for the reciprocal set reduction.
// One request at a time; a stalled result holds the next request. After
// reset the table rows are cleared, one per cycle, with input stalled.
`default_nettype none
module tcp_redirect_nat_table #(
    parameter int TABLE_SETS = tcpnat_pkg::TABLE_SETS_DEF,
    parameter int TABLE_WAYS = tcpnat_pkg::TABLE_WAYS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        direction,
    input  wire logic        ipv4_complete,
    input  wire logic [7:0]  ip_protocol,
    input  wire logic        tcp_complete,
    input  wire logic [31:0] src_ip,
    input  wire logic [31:0] dst_ip,
    input  wire logic [15:0] src_port,
    input  wire logic [15:0] dst_port,
    input  wire logic [7:0]  tcp_flags,
    input  wire logic [15:0] ip_checksum,
    input  wire logic [15:0] tcp_checksum,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       verdict,
    output logic             rewritten,
    output logic [31:0]      out_src_ip,
    output logic [31:0]      out_dst_ip,
    output logic [15:0]      out_src_port,
    output logic [15:0]      out_dst_port,
    output logic [15:0]      out_ip_checksum,
    output logic [15:0]      out_tcp_checksum
);
    localparam int SET_W   = $clog2(TABLE_SETS);
    localparam int AGE_W   = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int CW      = tcpnat_pkg::CLIENT_W;
    localparam int WAY_BITS = 1 + AGE_W + 2 * CW;
    localparam int ROW_W   = TABLE_WAYS * WAY_BITS;

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_PREP, ST_MODW, ST_EXEC} state_t;

    state_t            state_reg;
    logic [SET_W-1:0]  clr_reg;
    logic [SET_W-1:0]  set_reg;
    logic [15:0]       route_if_reg;
    logic [31:0]       redir_ip_reg;
    logic [15:0]       redir_pt_reg;

    logic        dir_reg, ipok_reg, tcpok_reg;
    logic [7:0]  proto_reg, flags_reg;
    logic [31:0] sip_reg, dip_reg;
    logic [15:0] sport_reg, dport_reg, ipc_reg, tcpc_reg;

    logic        out_valid_reg;
    logic [1:0]  verdict_reg;
    logic        rewritten_reg;
    logic [31:0] osip_reg, odip_reg;
    logic [15:0] osport_reg, odport_reg, oipc_reg, otcpc_reg;

    // ---- classification ----
    logic          is_tcp_path, need, egress;
    logic [CW-1:0] client;
    logic [1:0]    vd;

    always_comb
    begin
        egress      = dir_reg;
        is_tcp_path = ipok_reg && !(!egress && (proto_reg == tcpnat_pkg::PROTO_ICMP) &&
                      (route_if_reg != 16'd0)) && (proto_reg == tcpnat_pkg::PROTO_TCP) &&
                      tcpok_reg;
        vd = tcpnat_pkg::VERDICT_PASS;
        if (ipok_reg && !egress && (proto_reg == tcpnat_pkg::PROTO_ICMP) &&
            (route_if_reg != 16'd0))
        begin
            vd = tcpnat_pkg::VERDICT_ROUTE;
        end
        else if (ipok_reg && (proto_reg == tcpnat_pkg::PROTO_TCP) && !tcpok_reg)
        begin
            vd = tcpnat_pkg::VERDICT_DROP;
        end
        if (!egress)
        begin
            need   = is_tcp_path && !((dip_reg == redir_ip_reg) ||
                     tcpnat_pkg::is_lan(dip_reg) || (dport_reg == tcpnat_pkg::PORT_DNS));
            client = {sip_reg, sport_reg};
        end
        else
        begin
            need   = is_tcp_path && (sip_reg == redir_ip_reg) && (sport_reg == redir_pt_reg);
            client = {dip_reg, dport_reg};
        end
    end

    // ---- set index ----
    logic             mod_start, mod_done;
    logic [SET_W-1:0] mod_result;

    assign mod_start = (state_reg == ST_PREP) && need;

    tcpnat_setmod #(.TABLE_SETS(TABLE_SETS)) u_setmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .value  (tcpnat_pkg::client_hash(client)),
        .done   (mod_done),
        .result (mod_result)
    );

    // ---- table ----
    logic             rd_en, wr_en;
    logic [SET_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data, rd_data;
    logic             ex_go;
    logic             tbl_write;
    logic [ROW_W-1:0] row_next;

    assign rd_en   = ((state_reg == ST_PREP) || (state_reg == ST_MODW)) && need && mod_done;
    assign ex_go   = (state_reg == ST_EXEC) && !(out_valid_reg && out_stall);
    assign wr_en   = (state_reg == ST_CLEAR) || (ex_go && tbl_write);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_reg : set_reg;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : row_next;

    tcpnat_table #(.TABLE_SETS(TABLE_SETS), .ROW_W(ROW_W)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (mod_result),
        .rd_data (rd_data)
    );

    // ---- row update ----
    logic             v    [TABLE_WAYS];
    logic [AGE_W-1:0] ag   [TABLE_WAYS];
    logic [CW-1:0]    cl   [TABLE_WAYS];
    logic [CW-1:0]    og   [TABLE_WAYS];
    logic             hit, any_free, do_ins, do_del, syn_only;
    logic [AGE_W-1:0] hw, vic, tw;
    logic [AGE_W:0]   rank;
    logic [CW-1:0]    orig;

    always_comb
    begin
        for (int w = 0; w < TABLE_WAYS; w++)
        begin
            v[w]  = rd_data[w*WAY_BITS + WAY_BITS - 1];
            ag[w] = rd_data[w*WAY_BITS + 2*CW +: AGE_W];
            cl[w] = rd_data[w*WAY_BITS + CW +: CW];
            og[w] = rd_data[w*WAY_BITS +: CW];
        end
        hit = 1'b0;
        hw  = '0;
        any_free = 1'b0;
        vic = '0;
        for (int w = TABLE_WAYS - 1; w >= 0; w--)
        begin
            if (v[w] && (cl[w] == client))
            begin
                hit = 1'b1;
                hw  = AGE_W'(w);
            end
            if (!v[w])
            begin
                any_free = 1'b1;
                vic = AGE_W'(w);
            end
        end
        if (!any_free)
        begin
            for (int w = 1; w < TABLE_WAYS; w++)
            begin
                if (ag[w] > ag[vic])
                begin
                    vic = AGE_W'(w);
                end
            end
        end
        orig     = og[hw];
        syn_only = flags_reg[tcpnat_pkg::FLAG_SYN] && !flags_reg[tcpnat_pkg::FLAG_ACK];
        do_ins   = need && !egress && syn_only && !hit;
        do_del   = need && egress && hit && flags_reg[tcpnat_pkg::FLAG_FIN] &&
                   flags_reg[tcpnat_pkg::FLAG_ACK];
        // an inbound SYN without ACK for a known client leaves its entry and ranks untouched
        tbl_write = do_ins || (need && hit && (egress || !syn_only));

        tw   = do_ins ? vic : hw;
        rank = (do_ins && any_free) ? (AGE_W+1)'(TABLE_WAYS) : {1'b0, ag[tw]};

        if (do_del)
        begin
            for (int i = 0; i < TABLE_WAYS; i++)
            begin
                if (v[i] && ({1'b0, ag[i]} > rank))
                begin
                    ag[i] = ag[i] - AGE_W'(1);
                end
            end
            v[hw]  = 1'b0;
            ag[hw] = '0;
        end
        else
        begin
            for (int i = 0; i < TABLE_WAYS; i++)
            begin
                if ((i != int'(tw)) && v[i] && ({1'b0, ag[i]} < rank))
                begin
                    ag[i] = ag[i] + AGE_W'(1);
                end
            end
            ag[tw] = '0;
            if (do_ins)
            begin
                v[tw]  = 1'b1;
                cl[tw] = client;
                og[tw] = {dip_reg, dport_reg};
            end
        end
        for (int w = 0; w < TABLE_WAYS; w++)
        begin
            row_next[w*WAY_BITS +: WAY_BITS] = {v[w], ag[w], cl[w], og[w]};
        end
    end

    // ---- rewrite ----
    logic        go_in, go_eg;
    logic [31:0] n_sip, n_dip;
    logic [15:0] n_sport, n_dport, n_ipc, n_tcpc, t1;

    always_comb
    begin
        go_in   = need && !egress && (syn_only || hit);
        go_eg   = need && egress && hit;
        n_sip   = sip_reg;
        n_dip   = dip_reg;
        n_sport = sport_reg;
        n_dport = dport_reg;
        n_ipc   = ipc_reg;
        n_tcpc  = tcpc_reg;
        t1      = tcpc_reg;
        if (go_in)
        begin
            t1      = tcpnat_pkg::csum_fix(tcpc_reg, dip_reg, redir_ip_reg, 1'b1);
            n_ipc   = tcpnat_pkg::csum_fix(ipc_reg, dip_reg, redir_ip_reg, 1'b1);
            n_tcpc  = tcpnat_pkg::csum_fix(t1, {16'd0, dport_reg}, {16'd0, redir_pt_reg}, 1'b0);
            n_dip   = redir_ip_reg;
            n_dport = redir_pt_reg;
        end
        else if (go_eg)
        begin
            t1      = tcpnat_pkg::csum_fix(tcpc_reg, sip_reg, orig[47:16], 1'b1);
            n_ipc   = tcpnat_pkg::csum_fix(ipc_reg, sip_reg, orig[47:16], 1'b1);
            n_tcpc  = tcpnat_pkg::csum_fix(t1, {16'd0, sport_reg}, {16'd0, orig[15:0]}, 1'b0);
            n_sip   = orig[47:16];
            n_sport = orig[15:0];
        end
    end

    // ---- control ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            route_if_reg  <= '0;
            redir_ip_reg  <= '0;
            redir_pt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tcpnat_pkg::REG_ROUTE_IF: route_if_reg <= cfg_wdata[15:0];
                    tcpnat_pkg::REG_REDIR_IP: redir_ip_reg <= cfg_wdata;
                    tcpnat_pkg::REG_REDIR_PT: redir_pt_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (ex_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + SET_W'(1);
                    if (clr_reg == SET_W'(TABLE_SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    if (!need || mod_done)
                    begin
                        state_reg <= ST_EXEC;
                    end
                    else
                    begin
                        state_reg <= ST_MODW;
                    end
                end
                ST_MODW:
                begin
                    if (mod_done)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (ex_go)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            dir_reg   <= direction;
            ipok_reg  <= ipv4_complete;
            proto_reg <= ip_protocol;
            tcpok_reg <= tcp_complete;
            sip_reg   <= src_ip;
            dip_reg   <= dst_ip;
            sport_reg <= src_port;
            dport_reg <= dst_port;
            flags_reg <= tcp_flags;
            ipc_reg   <= ip_checksum;
            tcpc_reg  <= tcp_checksum;
        end
        if (rd_en)
        begin
            set_reg <= mod_result;
        end
        if (ex_go)
        begin
            verdict_reg   <= vd;
            rewritten_reg <= (n_sip != sip_reg) || (n_dip != dip_reg) ||
                             (n_sport != sport_reg) || (n_dport != dport_reg) ||
                             (n_ipc != ipc_reg) || (n_tcpc != tcpc_reg);
            osip_reg   <= n_sip;
            odip_reg   <= n_dip;
            osport_reg <= n_sport;
            odport_reg <= n_dport;
            oipc_reg   <= n_ipc;
            otcpc_reg  <= n_tcpc;
        end
    end

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign verdict          = verdict_reg;
    assign rewritten        = rewritten_reg;
    assign out_src_ip       = osip_reg;
    assign out_dst_ip       = odip_reg;
    assign out_src_port     = osport_reg;
    assign out_dst_port     = odport_reg;
    assign out_ip_checksum  = oipc_reg;
    assign out_tcp_checksum = otcpc_reg;

    // ---- checks ----
    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("request accepted during table clear");

    a_no_rewrite_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (verdict != tcpnat_pkg::VERDICT_PASS)) |-> !rewritten)
        else $error("rewrite on non-pass verdict");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == ST_CLEAR) || (state_reg == ST_EXEC)))
        else $error("table write outside clear or update");

    a_exec_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_EXEC))
        else $error("table read not followed by update");
endmodule
`default_nettype wire
